/* rtl/core/unsigned_to_decimal_ascii_defines.svh */
// Assertion macros for the unsigned to decimal ASCII converter.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define U2DA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define U2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/u2da_pkg.sv */
// Shared constants, sizing functions and types for the decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package u2da_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int DATA_IN_W       = 64;
    localparam int DATA_OUT_W      = 8;
    localparam int CHAR_W          = 6;
    localparam int BITS_PER_STEP   = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Decimal digits of 2^w - 1: floor(w * log10(2)) + 1, exact for w up to 64
    function automatic int num_digits(input int w);
        return (w * 77) / 256 + 1;
    endfunction

    // Double-dabble steps when BITS_PER_STEP bits are shifted in per cycle
    function automatic int num_steps(input int w);
        return (w + BITS_PER_STEP - 1) / BITS_PER_STEP;
    endfunction

    // Queue status seen by the top level
    typedef struct packed {
        logic empty;
        logic full;
    } u2da_qstat_t;

endpackage

/* rtl/core/u2da_front.sv */
// Front end: accepts one binary value and converts it to packed BCD digits
// by shift-and-add-3, then counts the significant digits. Uses u2da_pkg.
`timescale 1ns / 1ps

module u2da_front #(
    parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF,
    localparam int NUM_DIGITS = u2da_pkg::num_digits(VALUE_WIDTH),
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u2da_pkg::DATA_IN_W-1:0]     s_tdata,    // [63:0] value
    output logic                               push_valid,
    input  logic                               push_ready,
    output logic [NUM_DIGITS-1:0][3:0]         push_bcd,
    output logic [CNT_W-1:0]                   push_count
);
    import u2da_pkg::*;

    localparam int STEPS  = num_steps(VALUE_WIDTH);
    localparam int PAD_W  = STEPS * BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [PAD_W-1:0]           bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_dab;
    logic [PAD_W-1:0]           bin_dab;
    logic [CNT_W-1:0]           count_enc;

    // Run BITS_PER_STEP shift-and-add-3 iterations on the current word
    always_comb
    begin
        bcd_dab = bcd_reg;
        bin_dab = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_dab[d] >= 4'd5)
                begin
                    bcd_dab[d] = bcd_dab[d] + 4'd3;
                end
            end
            {bcd_dab, bin_dab} = {bcd_dab, bin_dab} << 1;
        end
    end

    // Count significant digits; zero still yields one digit
    always_comb
    begin
        count_enc = CNT_W'(1);
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                count_enc = CNT_W'(d + 1);
            end
        end
    end

    // Sequence: load, shift, hand over to the queue
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bin_next   = PAD_W'(s_tdata[VALUE_WIDTH-1:0]);
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                bin_next  = bin_dab;
                bcd_next  = bcd_dab;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Hold working data
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_DONE);
    assign push_bcd   = bcd_reg;
    assign push_count = count_enc;

endmodule

/* rtl/core/u2da_queue.sv */
// Short FIFO of converted entries (BCD digits and digit count) between the
// front and back ends. Uses u2da_pkg.
`timescale 1ns / 1ps

module u2da_queue #(
    parameter int ENTRY_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [ENTRY_W-1:0]         push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [ENTRY_W-1:0]         pop_data,
    output u2da_pkg::u2da_qstat_t      stat
);
    import u2da_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.empty = !pop_valid;
    assign stat.full  = !push_ready;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/u2da_back.sv */
// Back end: takes one BCD entry and sends its digits as ASCII beats, most
// significant first, through an output register. Uses u2da_pkg.
`timescale 1ns / 1ps

module u2da_back #(
    parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF,
    localparam int NUM_DIGITS = u2da_pkg::num_digits(VALUE_WIDTH),
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  logic [NUM_DIGITS-1:0][3:0]         pop_bcd,
    input  logic [CNT_W-1:0]                   pop_count,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u2da_pkg::DATA_OUT_W-1:0]    m_tdata,    // [5:0] digit_char
    output logic                               m_tlast     // last
);
    import u2da_pkg::*;

    localparam int IDX_W = $clog2(NUM_DIGITS);

    logic                       busy_reg, busy_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic                       valid_reg, valid_next;
    logic [CHAR_W-1:0]          char_reg, char_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           count_m1;
    logic                       can_load;

    assign pop_ready = !busy_reg;
    assign count_m1  = pop_count - CNT_W'(1);
    assign can_load  = !valid_reg || m_tready;

    // Load an entry when free, otherwise emit one digit per free output slot
    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        bcd_next   = bcd_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                bcd_next  = pop_bcd;
                idx_next  = count_m1[IDX_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (can_load)
        begin
            valid_next = 1'b1;
            char_next  = ASCII_ZERO + {2'b00, bcd_reg[idx_reg]};
            last_next  = (idx_reg == '0);
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // Hold digit data and the output beat
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, char_reg};
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/unsigned_to_decimal_ascii.sv */
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on u2da_pkg, u2da_front, u2da_queue, u2da_back and the defines header.
//
//  Channel | Dir | Signals                      | Payload
//  s_*     | in  | s_tvalid s_tready s_tdata    | tdata[63:0] value
//  m_*     | out | m_tvalid m_tready m_tdata     | tdata[5:0] digit_char, tlast last
//                  m_tlast                       |
//
// The front converter takes a new value only after it has pushed the last one
// to the queue; the shift-and-add-3 loop moves four bits per cycle.
// The back end sends one digit per cycle while m_tready is high, up to 20 digits
// per value at 64 bits, and loads each entry from the queue before its first digit.
// A two-entry queue between them lets conversion run ahead of a stalled output.
// Reset is asynchronous, active low, and clears all control state.
`timescale 1ns / 1ps

`include "unsigned_to_decimal_ascii_defines.svh"

module unsigned_to_decimal_ascii #(
    parameter int VALUE_WIDTH = u2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u2da_pkg::DATA_IN_W-1:0]     s_tdata,    // [63:0] value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u2da_pkg::DATA_OUT_W-1:0]    m_tdata,    // [5:0] digit_char, [7:6] zero
    output logic                               m_tlast     // last
);
    import u2da_pkg::*;

    localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int ENTRY_W    = NUM_DIGITS * 4 + CNT_W;

    logic                       push_valid;
    logic                       push_ready;
    logic [NUM_DIGITS-1:0][3:0] push_bcd;
    logic [CNT_W-1:0]           push_count;
    logic                       pop_valid;
    logic                       pop_ready;
    logic [NUM_DIGITS-1:0][3:0] pop_bcd;
    logic [CNT_W-1:0]           pop_count;
    logic [ENTRY_W-1:0]         pop_entry;
    u2da_qstat_t                q_stat;

    u2da_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_bcd   (push_bcd),
        .push_count (push_count)
    );

    u2da_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_bcd, push_count}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry),
        .stat       (q_stat)
    );

    assign {pop_bcd, pop_count} = pop_entry;

    u2da_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_bcd   (pop_bcd),
        .pop_count (pop_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // The converter is not ready in the cycle after taking a value
    `U2DA_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took two beats")

    // Every entry handed to the back end has between one and NUM_DIGITS digits
    `U2DA_ASSERT_IMPL(a_count_range, pop_valid && pop_ready, (pop_count != '0) && (pop_count <= CNT_W'(NUM_DIGITS)), "digit count out of range")

    // An entry pushed without a pop leaves the queue non-empty
    `U2DA_ASSERT_NEXT(a_queue_fill, push_valid && push_ready && !(pop_valid && pop_ready), !q_stat.empty && (q_stat.full || pop_valid), "queue lost an entry")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the unsigned binary to decimal ASCII converter.
// Depends on u2da_pkg and unsigned_to_decimal_ascii; checks every digit beat against
// a predicted digit string.
`timescale 1ns / 1ps

module testbench;

    import u2da_pkg::*;

    localparam int  VALUE_WIDTH  = VALUE_WIDTH_DEF;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  SETTLE_TICKS = 40;
    localparam int  RANDOM_ITEMS = 132;
    localparam int  PRINT_CAP    = 200;

    // One expected output beat
    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } digit_beat_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_RUNS
    } rx_mode_t;

    // Digit string predictor and checker
    class decimal_digit_tracker;
        digit_beat_t digits_due[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return digits_due.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        // Work out the decimal digits of an accepted value, most significant first
        function void note_value(logic [DATA_IN_W-1:0] raw);
            logic [63:0]       operand;
            logic [63:0]       op_mask;
            logic [CHAR_W-1:0] msd_first[$];
            digit_beat_t       beat;
            op_mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
            operand = raw & op_mask;
            do
            begin
                msd_first.push_front(ASCII_ZERO + CHAR_W'(operand % 64'd10));
                operand = operand / 64'd10;
            end
            while (operand != 64'd0);
            foreach (msd_first[k])
            begin
                beat.digit_char = msd_first[k];
                beat.last       = (k == msd_first.size() - 1);
                digits_due.push_back(beat);
            end
        endfunction

        // Compare one accepted output beat with the oldest expected digit
        task check_digit(logic [DATA_OUT_W-1:0] tdata, logic tlast);
            digit_beat_t want;
            if (digits_due.size() == 0)
            begin
                report($sformatf("digit 0x%02h last=%0b with nothing expected", tdata, tlast));
            end
            else
            begin
                want = digits_due.pop_front();
                if (tdata[CHAR_W-1:0] !== want.digit_char)
                    report($sformatf("digit_char %0d, expected %0d",
                                     tdata[CHAR_W-1:0], want.digit_char));
                if (tlast !== want.last)
                    report($sformatf("last %0b, expected %0b on digit %0d",
                                     tlast, want.last, want.digit_char));
            end
        endtask
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata  = '0;   // [63:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;         // [5:0] digit_char, [7:6] zero
    logic                  m_tlast;         // last

    decimal_digit_tracker tracker = new();
    int                   hold_off_left = 0;
    int                   cycle_count   = 0;

    unsigned_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Check every digit beat taken from the output
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_digit(m_tdata, m_tlast);
    end

    // Offer one value and hold it until the converter takes it
    task send_value(logic [DATA_IN_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_value(value);
    endtask

    // Drop valid for a number of cycles
    task idle_input(int ticks);
        if (ticks > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (ticks) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding digit
    task drain_output();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] pow10;
        int          exponent;
        pow10 = 64'd1;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} >> $urandom_range(0, 63);
            2: return 64'($urandom_range(0, 999));
            default:
            begin
                // Straddle a power of ten, where the digit count changes
                exponent = $urandom_range(1, 19);
                repeat (exponent) pow10 = pow10 * 64'd10;
                return pow10 + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
    endfunction

    // Receiver: own stall pattern, plus a long hold-off on request
    initial
    begin : rx_pattern
        rx_mode_t mode;
        int       mode_left;
        int       run_left;
        logic     run_ready;
        mode      = RX_FREE;
        mode_left = 0;
        run_left  = 0;
        run_ready = 1'b1;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_ready = ~run_ready;
                            run_left  = $urandom_range(1, 8);
                        end
                        run_left--;
                        m_tready <= run_ready;
                    end
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [63:0] directed_values[$];
        int          burst_left;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values: extremes, digit-count boundaries, bit patterns
        directed_values = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
            64'd1234567890, 64'd4294967295, 64'd4294967296,
            64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'd9999999999999999999, 64'd10000000000000000000,
            64'd18446744073709551614, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF
        };
        foreach (directed_values[i])
        begin
            send_value(directed_values[i]);
            if (i % 5 == 4)
                idle_input($urandom_range(1, 4));
        end

        // Random values in bursts
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 95)
            begin
                drain_output();
            end
            else if (burst_left <= 0)
            begin
                idle_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
                burst_left = $urandom_range(1, 12);
            end
            // Stall the output for a long stretch while input keeps coming
            if (i == 40)
                hold_off_left = 400;
            burst_left--;
            send_value(random_value());
        end

        drain_output();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
